[hdl/lrupfr_pkg.sv]
`timescale 1ns / 1ps
package lrupfr_pkg;

  localparam int MAX_FRAMES_DEF = 8;
  localparam int PAGE_BITS_DEF  = 16;
  localparam int CFG_W          = 4;
  localparam int SLOT_OUT_W     = 3;
  localparam int CNT_W          = 32;
  localparam logic [CFG_W-1:0] FRAMES_RESET = 4'd8;

  // update command from the control path to the stores
  typedef struct packed {
    logic en;    // an item retires this cycle
    logic hit;   // referenced page was resident
    logic fill;  // page goes into the next empty frame
    logic evict; // page replaces the LRU frame
  } upd_t;

endpackage

[hdl/lrupfr_frames.sv]
`timescale 1ns / 1ps
module lrupfr_frames #(
  parameter int MAX_FRAMES = lrupfr_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = lrupfr_pkg::PAGE_BITS_DEF,
  localparam int SLOT_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
  localparam int COUNT_W = $clog2(MAX_FRAMES + 1)
) (
  input  logic                 clk,
  input  logic [PAGE_BITS-1:0] lookup_page,
  input  logic [COUNT_W-1:0]   filled_count,
  output logic                 match,
  output logic [SLOT_W-1:0]    match_slot,
  input  logic [SLOT_W-1:0]    rd_slot,
  output logic [PAGE_BITS-1:0] rd_page,
  input  logic                 wr_en,
  input  logic [SLOT_W-1:0]    wr_slot,
  input  logic [PAGE_BITS-1:0] wr_page
);

  logic [PAGE_BITS-1:0] frame_page [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] hit_vec;

  // a page sits in at most one filled frame, so OR the matching indexes
  always_comb begin
    match_slot = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      hit_vec[i] = (i < int'(filled_count)) && (frame_page[i] == lookup_page);
      if (hit_vec[i]) begin
        match_slot = match_slot | SLOT_W'(i);
      end
    end
    match = |hit_vec;
  end

  assign rd_page = frame_page[rd_slot];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_page[wr_slot] <= wr_page;
    end
  end

endmodule

[hdl/lrupfr_ranks.sv]
`timescale 1ns / 1ps
module lrupfr_ranks #(
  parameter int MAX_FRAMES = lrupfr_pkg::MAX_FRAMES_DEF,
  localparam int SLOT_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
  localparam int COUNT_W = $clog2(MAX_FRAMES + 1)
) (
  input  logic                clk,
  input  logic [COUNT_W-1:0]  filled_count,
  output logic [SLOT_W-1:0]   victim_slot,
  input  lrupfr_pkg::upd_t    upd,
  input  logic [SLOT_W-1:0]   tgt_slot
);

  // rank 0 is most recent; filled frames always hold 0 .. filled_count-1
  logic [SLOT_W-1:0]  recency_rank [MAX_FRAMES];
  logic [COUNT_W-1:0] oldest;
  logic [COUNT_W-1:0] thresh;

  assign oldest = filled_count - COUNT_W'(1);

  // ranks form a permutation, so exactly one filled frame holds the oldest rank
  always_comb begin
    victim_slot = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if ((i < int'(filled_count)) && (COUNT_W'(recency_rank[i]) == oldest)) begin
        victim_slot = victim_slot | SLOT_W'(i);
      end
    end
  end

  // on a fill every filled frame ages; otherwise those newer than the target
  assign thresh = upd.fill ? filled_count : COUNT_W'(recency_rank[tgt_slot]);

  always_ff @(posedge clk) begin
    if (upd.en) begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
        if ((i < int'(filled_count)) && (SLOT_W'(i) != tgt_slot) &&
            (COUNT_W'(recency_rank[i]) < thresh)) begin
          recency_rank[i] <= recency_rank[i] + SLOT_W'(1);
        end
      end
      recency_rank[tgt_slot] <= '0;
    end
  end

endmodule

[hdl/lru_page_frame_replacer_core.sv]
`timescale 1ns / 1ps
// An accepted item waits in the input register until the result register is free or draining.
// Throughput: one item per cycle while the output is not stalled; the tag match, LRU pick
//   and rank update all settle combinationally between the input and result registers.
// Reset (rst, synchronous): clears the filled count, hit/fault counters, valid flags
//   and sets frames_in_use to 8; frame pages and ranks need no clearing pass.
module lru_page_frame_replacer_core #(
  parameter int MAX_FRAMES = lrupfr_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = lrupfr_pkg::PAGE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_we,
  input  logic [lrupfr_pkg::CFG_W-1:0]      cfg_data,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [PAGE_BITS-1:0]              page_number,
  // output channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              hit,
  output logic [lrupfr_pkg::SLOT_OUT_W-1:0] frame_slot,
  output logic                              evicted,
  output logic [PAGE_BITS-1:0]              evicted_page,
  output logic [lrupfr_pkg::CNT_W-1:0]      hit_total,
  output logic [lrupfr_pkg::CNT_W-1:0]      fault_total
);

  localparam int SLOT_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int COUNT_W = $clog2(MAX_FRAMES + 1);
  localparam int CNT_W   = lrupfr_pkg::CNT_W;

  // configuration register
  logic [lrupfr_pkg::CFG_W-1:0] frames_in_use;
  logic [COUNT_W-1:0]           lim;

  // input register
  logic                 s1_valid;
  logic [PAGE_BITS-1:0] s1_page;

  // block state
  logic [COUNT_W-1:0] filled_count;
  logic [CNT_W-1:0]   hit_counter;
  logic [CNT_W-1:0]   fault_counter;
  logic [CNT_W-1:0]   hit_counter_next;
  logic [CNT_W-1:0]   fault_counter_next;

  // lookup results
  logic                 lk_hit;
  logic [SLOT_W-1:0]    lk_slot;
  logic [SLOT_W-1:0]    victim_slot;
  logic [PAGE_BITS-1:0] victim_page;
  logic [SLOT_W-1:0]    tgt_slot;
  logic                 advance;
  lrupfr_pkg::upd_t     upd;

  // Retire the held item whenever the result register is empty or being drained.
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  // Clamp the limit: zero means one frame, anything past the store means all of it.
  always_comb begin
    if (frames_in_use == '0) begin
      lim = COUNT_W'(1);
    end else if (int'(frames_in_use) > MAX_FRAMES) begin
      lim = COUNT_W'(MAX_FRAMES);
    end else begin
      lim = COUNT_W'(frames_in_use);
    end
  end

  lrupfr_frames #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_frames (
    .clk          (clk),
    .lookup_page  (s1_page),
    .filled_count (filled_count),
    .match        (lk_hit),
    .match_slot   (lk_slot),
    .rd_slot      (victim_slot),
    .rd_page      (victim_page),
    .wr_en        (upd.en && !upd.hit),
    .wr_slot      (tgt_slot),
    .wr_page      (s1_page)
  );

  lrupfr_ranks #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_ranks (
    .clk          (clk),
    .filled_count (filled_count),
    .victim_slot  (victim_slot),
    .upd          (upd),
    .tgt_slot     (tgt_slot)
  );

  // A miss fills the next empty frame while under the limit, else replaces the LRU.
  always_comb begin
    upd.en    = advance;
    upd.hit   = lk_hit;
    upd.fill  = !lk_hit && (filled_count < lim);
    upd.evict = !lk_hit && !(filled_count < lim);
    if (upd.hit) begin
      tgt_slot = lk_slot;
    end else if (upd.fill) begin
      tgt_slot = SLOT_W'(filled_count);
    end else begin
      tgt_slot = victim_slot;
    end
  end

  // Saturating hit and fault counts.
  always_comb begin
    hit_counter_next   = hit_counter;
    fault_counter_next = fault_counter;
    if (lk_hit) begin
      if (hit_counter != '1) hit_counter_next = hit_counter + CNT_W'(1);
    end else begin
      if (fault_counter != '1) fault_counter_next = fault_counter + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= lrupfr_pkg::FRAMES_RESET;
    end else if (cfg_we) begin
      frames_in_use <= cfg_data;
    end
  end

  // Input register: take a new item when empty or when the held one retires.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_page <= page_number;
    end
  end

  // Commit state as the item retires.
  always_ff @(posedge clk) begin
    if (rst) begin
      filled_count  <= '0;
      hit_counter   <= '0;
      fault_counter <= '0;
    end else if (advance) begin
      hit_counter   <= hit_counter_next;
      fault_counter <= fault_counter_next;
      if (upd.fill) begin
        filled_count <= filled_count + COUNT_W'(1);
      end
    end
  end

  // Result register: load on retire, drop once the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hit          <= lk_hit;
      frame_slot   <= lrupfr_pkg::SLOT_OUT_W'(tgt_slot);
      evicted      <= upd.evict;
      evicted_page <= upd.evict ? victim_page : '0;
      hit_total    <= hit_counter_next;
      fault_total  <= fault_counter_next;
    end
  end

  a_filled_bound: assert property (@(posedge clk) disable iff (rst)
    filled_count <= COUNT_W'(MAX_FRAMES))
    else $error("filled count beyond frame store");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    advance && upd.fill |=> filled_count == COUNT_W'($past(filled_count) + COUNT_W'(1)))
    else $error("fill did not advance filled count");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && evicted))
    else $error("result flags both hit and eviction");

  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    advance && upd.evict |-> filled_count != '0 && filled_count >= lim)
    else $error("eviction while a frame is still free");

  a_retire_shows: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("retired item missing from result register");

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
module testbench;

  localparam int PW = lrupfr_pkg::PAGE_BITS_DEF;
  localparam int NF = lrupfr_pkg::MAX_FRAMES_DEF;
  localparam int CFG_W = lrupfr_pkg::CFG_W;
  localparam int SLOT_OUT_W = lrupfr_pkg::SLOT_OUT_W;
  localparam int CNT_W = lrupfr_pkg::CNT_W;
  localparam int HOLD_CYCLES = 60;      // long receiver hold-off used for back-pressure
  localparam int WATCHDOG_LIMIT = 3000; // cycles with no item moving on either side
  localparam int DRAIN_CYCLES = 4;      // leave slack for stray results

  typedef struct packed {
    logic                  hit;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  evicted;
    logic [PW-1:0]         evicted_page;
    logic [CNT_W-1:0]      hit_total;
    logic [CNT_W-1:0]      fault_total;
  } lookup_t;

  // One row of the directed table: either a frame-limit write or a page
  // reference, optionally with a hand-typed expected lookup.
  typedef struct packed {
    logic             is_cfg;
    logic [CFG_W-1:0] frames;
    logic [PW-1:0]    page;
    logic             typed;
    lookup_t          want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [PW-1:0] page_number = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic hit;
  logic [SLOT_OUT_W-1:0] frame_slot;
  logic evicted;
  logic [PW-1:0] evicted_page;
  logic [CNT_W-1:0] hit_total;
  logic [CNT_W-1:0] fault_total;

  lru_page_frame_replacer_core DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .page_number(page_number),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .hit(hit),
    .frame_slot(frame_slot),
    .evicted(evicted),
    .evicted_page(evicted_page),
    .hit_total(hit_total),
    .fault_total(fault_total)
  );

  always #10 clk = ~clk;

  // Shadow of the replacer: resident pages, recency ranks (0 = newest),
  // filled count, saturating counters and the programmed frame limit.
  logic [PW-1:0]    shadow_page [NF];
  logic [2:0]       shadow_rank [NF];
  int               shadow_filled = 0;
  logic [CNT_W-1:0] shadow_hits = '0;
  logic [CNT_W-1:0] shadow_faults = '0;
  logic [CFG_W-1:0] shadow_frames = lrupfr_pkg::FRAMES_RESET;

  lookup_t expected_lookups [$];
  int mismatch_count = 0;
  int lookups_checked = 0;
  int hits_seen = 0;

  // Idle rates in percent for each side, changed per phase.
  int send_idle_pct = 11;
  int recv_idle_pct = 76;
  logic hold_pending = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  // Move frame s to the front; frames that were newer than it age by one.
  function automatic void promote_frame(input int s);
    logic [2:0] r;
    r = shadow_rank[s];
    for (int i = 0; i < shadow_filled; i++)
      if (i != s && shadow_rank[i] < r) shadow_rank[i]++;
    shadow_rank[s] = '0;
  endfunction

  function automatic lookup_t predict_lookup(input logic [PW-1:0] pg);
    lookup_t res;
    int limit;
    int worst;
    bit found;
    res = '0;
    found = 0;
    limit = (shadow_frames == 0) ? 1 : (shadow_frames > NF) ? NF : int'(shadow_frames);
    for (int i = 0; i < shadow_filled; i++)
      if (!found && shadow_page[i] == pg) begin
        found = 1;
        res.slot = SLOT_OUT_W'(i);
      end
    if (found) begin
      if (shadow_hits != '1) shadow_hits++;
      promote_frame(int'(res.slot));
    end else begin
      if (shadow_faults != '1) shadow_faults++;
      if (shadow_filled < limit) begin
        // free frame: everyone ages, newcomer is newest
        res.slot = SLOT_OUT_W'(shadow_filled);
        for (int i = 0; i < shadow_filled; i++) shadow_rank[i]++;
        shadow_page[shadow_filled] = pg;
        shadow_rank[shadow_filled] = '0;
        shadow_filled++;
      end else begin
        // replace the oldest filled frame; ties go to the higher index
        worst = 0;
        for (int i = 0; i < shadow_filled; i++)
          if (shadow_rank[i] >= shadow_rank[worst]) worst = i;
        res.slot = SLOT_OUT_W'(worst);
        res.evicted = 1'b1;
        res.evicted_page = shadow_page[worst];
        shadow_page[worst] = pg;
        promote_frame(worst);
      end
    end
    res.hit = found;
    res.hit_total = shadow_hits;
    res.fault_total = shadow_faults;
    return res;
  endfunction

  // Offer one page reference and hold it until the block takes it. Valid is
  // left high on return so back-to-back items stream without a bubble.
  task automatic send_page(input logic [PW-1:0] pg, input logic typed, input lookup_t want);
    lookup_t pred;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    page_number = pg;
    do @(posedge clk); while (in_stall);
    pred = predict_lookup(pg);
    if (typed) pred = want;
    expected_lookups = {expected_lookups, pred};
  endtask

  // Drop valid, then wait until every pending lookup has come back.
  task automatic wait_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_frames(input logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_data = CFG_W'($urandom);
    shadow_frames = v;
  endtask

  // Random references: most come from a small working set so the frames
  // actually hit and the LRU order matters; the rest are arbitrary pages.
  task automatic run_random(input int count);
    logic [PW-1:0] pool [10];
    int pool_n;
    logic [PW-1:0] pg;
    foreach (pool[k]) pool[k] = PW'($urandom);
    pool_n = 6;
    for (int n = 0; n < count; n++) begin
      if (n % 20 == 0) begin
        pool_n = $urandom_range(1, 10);
        pool[$urandom_range(0, 9)] = PW'($urandom);
      end
      if ($urandom_range(0, 99) < 75) pg = pool[$urandom_range(0, pool_n - 1)];
      else pg = PW'($urandom);
      send_page(pg, 1'b0, '0);
    end
  endtask

  // Receiver side: honor a requested long hold-off first, else stall at
  // the current random rate. Counts its own hold cycles.
  always @(negedge clk) begin
    if (hold_pending) begin
      hold_left = HOLD_CYCLES;
      hold_pending = 1'b0;
    end
    if (hold_left != 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Check each delivered lookup against the oldest expectation.
  always @(posedge clk) begin
    lookup_t got;
    lookup_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{hit, frame_slot, evicted, evicted_page, hit_total, fault_total};
      if (expected_lookups.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result with no lookup pending: %p", $realtime, got);
      end else begin
        want = expected_lookups.pop_front();
        lookups_checked++;
        if (got.hit) hits_seen++;
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: lookup mismatch\n  expected %p\n  actual   %p",
                     $realtime, want, got);
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d lookups pending",
                 $realtime, expected_lookups.size());
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // Directed table. Typed rows can be read off directly: with a single
  // frame, the first page faults into frame 0, repeats hit, and the next
  // distinct page evicts it. All other rows go through the predictor.
  row_t directed [] = '{
    '{1'b1, 4'd0,  16'h0000, 1'b0, '0},                       // zero frames acts as one
    '{1'b0, 4'd0,  16'h0000, 1'b1, '{1'b0, 3'd0, 1'b0, 16'h0000, 32'd0, 32'd1}},
    '{1'b0, 4'd0,  16'h0000, 1'b1, '{1'b1, 3'd0, 1'b0, 16'h0000, 32'd1, 32'd1}},
    '{1'b0, 4'd0,  16'hFFFF, 1'b1, '{1'b0, 3'd0, 1'b1, 16'h0000, 32'd1, 32'd2}},
    '{1'b1, 4'd3,  16'h0000, 1'b0, '0},
    '{1'b0, 4'd0,  16'h1234, 1'b0, '0},
    '{1'b0, 4'd0,  16'h5678, 1'b0, '0},
    '{1'b0, 4'd0,  16'hFFFF, 1'b0, '0},                       // hit on the oldest fill
    '{1'b0, 4'd0,  16'hAAAA, 1'b0, '0},                       // evict LRU
    '{1'b0, 4'd0,  16'h5555, 1'b0, '0},
    '{1'b1, 4'd15, 16'h0000, 1'b0, '0},                       // above max saturates to 8
    '{1'b0, 4'd0,  16'h0001, 1'b0, '0},
    '{1'b0, 4'd0,  16'h8000, 1'b0, '0},
    '{1'b0, 4'd0,  16'h00FF, 1'b0, '0},
    '{1'b0, 4'd0,  16'h7F00, 1'b0, '0},
    '{1'b0, 4'd0,  16'h0F0F, 1'b0, '0},                       // all eight frames filled
    '{1'b0, 4'd0,  16'h3C3C, 1'b0, '0},
    '{1'b1, 4'd2,  16'h0000, 1'b0, '0},                       // limit below filled count
    '{1'b0, 4'd0,  16'h8000, 1'b0, '0},
    '{1'b0, 4'd0,  16'hF0F0, 1'b0, '0},
    '{1'b0, 4'd0,  16'h00FF, 1'b0, '0},
    '{1'b0, 4'd0,  16'h0000, 1'b0, '0}
  };

  initial begin
    // Hold reset, then release it on a falling edge.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part under the first idle mix.
    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        wait_drain();
        write_frames(directed[i].frames);
      end else begin
        send_page(directed[i].page, directed[i].typed, directed[i].want);
      end
    end

    // Phase 1: sender rarely idles, receiver mostly stalls.
    wait_drain();
    write_frames(4'd8);
    send_idle_pct = 11;
    recv_idle_pct = 76;
    run_random(130);

    // Phase 2: the other way round.
    wait_drain();
    write_frames(CFG_W'($urandom_range(0, 15)));
    send_idle_pct = 76;
    recv_idle_pct = 11;
    run_random(130);

    // Phase 3: no idling, opened by a long receiver hold-off so the
    // pipeline backs up and stalls the input while items keep coming.
    wait_drain();
    write_frames(4'd1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_pending = 1'b1;
    run_random(140);

    wait_drain();
    mismatch_count += expected_lookups.size();
    $display("testbench: %0d lookups checked, %0d hits; frame limits 0, 1, 2, 3, 8, 15 written",
             lookups_checked, hits_seen);
    $display("testbench: idle mixes 11/76, 76/11, none, plus a %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (mismatch_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
